>>> src/csw_pkg.sv
// Shared types and constants for the CT slice window/level block.
// Used by every module of the block; depends on nothing.
package csw_pkg;

	localparam int AddrW  = 27;
	localparam int DestW  = 18;
	localparam int HuW    = 16;
	localparam int GrayW  = 8;
	localparam int WinW   = 16;
	localparam int NumW   = 24;
	localparam int DimW   = 10;
	localparam int SliceW = 9;
	localparam int ApbAw  = 5;
	localparam int ApbDw  = 32;
	localparam int TdataW = 56;

	localparam logic [GrayW-1:0] GRAY_MAX = 8'd255;

	typedef enum logic [1:0] {
		ORIENT_AXIAL    = 2'd0,
		ORIENT_CORONAL  = 2'd1,
		ORIENT_SAGITTAL = 2'd2
	} orient_t;

	typedef enum logic [2:0] {
		REG_ORIENT = 3'd0,
		REG_DIM_X  = 3'd1,
		REG_DIM_Y  = 3'd2,
		REG_DIM_Z  = 3'd3,
		REG_SLICE  = 3'd4,
		REG_LEVEL  = 3'd5,
		REG_WIDTH  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]             orientation;
		logic [DimW-1:0]        dim_x;
		logic [DimW-1:0]        dim_y;
		logic [DimW-1:0]        dim_z;
		logic [SliceW-1:0]      slice_index;
		logic signed [HuW-1:0]  window_level;
		logic [WinW-1:0]        window_width;
	} cfg_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [DestW-1:0] dest;
		logic             last;
		logic             below;
		logic             above;
		logic [NumW-1:0]  rem;
		logic [GrayW-1:0] quo;
	} cell_t;

endpackage

>>> src/ct_slice_window_level.sv
// Top level of the CT slice window/level block: APB registers, front stages
// and the divider cell chain. Depends on csw_pkg, csw_front, csw_div_cell.
//
// Walks one axial, coronal or sagittal slice of a CT volume and maps each
// incoming Hounsfield sample to an 8-bit grey level, together with its voxel
// address, its texture index (rows flipped for coronal and sagittal) and an
// end-of-slice mark on tlast. One request is taken per clock cycle while the
// output is not stalled; each passes through two stages of counters and
// multipliers, one stage of address sums, then eight divider cells that each
// settle one bit of the grey level. A stalled output holds the whole chain.
// Any register write restarts the walk at the first pixel; write registers
// only while no request is in flight.
module ct_slice_window_level #(
	parameter int MAX_DIM = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [csw_pkg::HuW-1:0]     s_tdata,  // [15:0] hu_sample
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [csw_pkg::TdataW-1:0]  m_tdata,  // [7:0] gray, [34:8] source_address,
	                                              // [52:35] dest_index, [55:53] zero
	output logic                        m_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csw_pkg::ApbAw-1:0]   paddr,
	input  logic [csw_pkg::ApbDw-1:0]   pwdata,
	output logic [csw_pkg::ApbDw-1:0]   prdata,
	output logic                        pready
);

	csw_pkg::cfg_t     cfg_q;
	csw_pkg::reg_idx_t ridx;
	logic              cfg_wr, adv, in_acc;
	logic [8:0]        cv;
	csw_pkg::cell_t    cd [0:8];
	logic [csw_pkg::GrayW-1:0] gray;

	assign pready = 1'b1;
	assign ridx   = csw_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation  <= csw_pkg::ORIENT_AXIAL;
			cfg_q.dim_x        <= 10'd1;
			cfg_q.dim_y        <= 10'd1;
			cfg_q.dim_z        <= 10'd1;
			cfg_q.slice_index  <= '0;
			cfg_q.window_level <= 16'sd41;
			cfg_q.window_width <= 16'd85;
		end else if (cfg_wr) begin
			case (ridx)
				csw_pkg::REG_ORIENT: cfg_q.orientation  <= pwdata[1:0];
				csw_pkg::REG_DIM_X:  cfg_q.dim_x        <= pwdata[csw_pkg::DimW-1:0];
				csw_pkg::REG_DIM_Y:  cfg_q.dim_y        <= pwdata[csw_pkg::DimW-1:0];
				csw_pkg::REG_DIM_Z:  cfg_q.dim_z        <= pwdata[csw_pkg::DimW-1:0];
				csw_pkg::REG_SLICE:  cfg_q.slice_index  <= pwdata[csw_pkg::SliceW-1:0];
				csw_pkg::REG_LEVEL:  cfg_q.window_level <= $signed(pwdata[csw_pkg::HuW-1:0]);
				csw_pkg::REG_WIDTH:  cfg_q.window_width <= pwdata[csw_pkg::WinW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			csw_pkg::REG_ORIENT: prdata = csw_pkg::ApbDw'(cfg_q.orientation);
			csw_pkg::REG_DIM_X:  prdata = csw_pkg::ApbDw'(cfg_q.dim_x);
			csw_pkg::REG_DIM_Y:  prdata = csw_pkg::ApbDw'(cfg_q.dim_y);
			csw_pkg::REG_DIM_Z:  prdata = csw_pkg::ApbDw'(cfg_q.dim_z);
			csw_pkg::REG_SLICE:  prdata = csw_pkg::ApbDw'(cfg_q.slice_index);
			csw_pkg::REG_LEVEL:  prdata = {16'd0, cfg_q.window_level};
			csw_pkg::REG_WIDTH:  prdata = csw_pkg::ApbDw'(cfg_q.window_width);
			default:             prdata = '0;
		endcase
	end

	// advance the whole chain unless the output request is held
	assign adv      = !cv[8] || m_tready;
	assign s_tready = adv;
	assign in_acc   = s_tvalid && adv;

	csw_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_wr   (cfg_wr),
		.adv      (adv),
		.in_acc   (in_acc),
		.hu       ($signed(s_tdata)),
		.v_out    (cv[0]),
		.cell_out (cd[0])
	);

	for (genvar gi = 0; gi < 8; gi++) begin : g_cell
		csw_div_cell #(
			.BIT (7 - gi)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.v_in    (cv[gi]),
			.d_in    (cd[gi]),
			.divisor (cfg_q.window_width),
			.v_out   (cv[gi+1]),
			.d_out   (cd[gi+1])
		);
	end

	always_comb begin
		if (cd[8].below) gray = '0;
		else if (cd[8].above) gray = csw_pkg::GRAY_MAX;
		else gray = cd[8].quo;
	end

	assign m_tvalid = cv[8];
	assign m_tdata  = {3'd0, cd[8].dest, cd[8].addr, gray};
	assign m_tlast  = cd[8].last;

endmodule

>>> src/csw_div_cell.sv
// One cell of the grey-level divider chain: resolves one quotient bit.
// Depends on csw_pkg.
module csw_div_cell #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           v_in,
	input  csw_pkg::cell_t d_in,
	input  logic [csw_pkg::WinW-1:0] divisor,
	output logic           v_out,
	output csw_pkg::cell_t d_out
);

	logic [csw_pkg::NumW-1:0] dsh;
	csw_pkg::cell_t nxt;

	assign dsh = csw_pkg::NumW'(divisor) << BIT;

	always_comb begin
		nxt = d_in;
		if (d_in.rem >= dsh) begin
			nxt.rem      = d_in.rem - dsh;
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_out <= nxt;
		end
	end

endmodule

>>> src/csw_front.sv
// Walk counters, address and texture index stages, window classification.
// Feeds the divider chain; depends on csw_pkg.
module csw_front #(
	parameter int MAX_DIM = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  csw_pkg::cfg_t  cfg,
	input  logic           cfg_wr,
	input  logic           adv,
	input  logic           in_acc,
	input  logic signed [csw_pkg::HuW-1:0] hu,
	output logic           v_out,
	output csw_pkg::cell_t cell_out
);

	localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int PW = 2 * DW;
	localparam int AW = csw_pkg::AddrW;
	localparam int EW = csw_pkg::DestW;

	function automatic logic [DW-1:0] eff_dim(input logic [csw_pkg::DimW-1:0] v);
		logic [DW-1:0] r;
		begin
			if (v == '0) r = DW'(1);
			else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
			else r = DW'(v);
			return r;
		end
	endfunction

	logic [DW-1:0] dx, dy, dz, w, h, y2d;
	logic          axial, coronal, sagittal;
	logic [CW-1:0] col_q, row_q;
	logic [DW:0]   col_nx, row_nx;
	logic          row_end, last;
	logic [PW-1:0] plane_q, bstep, rstep, cstep;
	logic signed [csw_pkg::HuW:0] lo_q, hi_q;

	logic                  v_s1, v_s2;
	logic [CW-1:0]         c_s1, c_s2;
	logic [CW-1:0]         r_s1;
	logic [DW-1:0]         y2d_s1;
	logic signed [csw_pkg::HuW-1:0] hu_s1;
	logic                  last_s1, last_s2;
	logic [AW-1:0]         base_s2, rowp_s2, colp_s2;
	logic [EW-1:0]         dmul_s2;
	logic                  below_s2, above_s2;
	logic [csw_pkg::WinW-1:0] diff_s2;
	logic signed [csw_pkg::HuW:0] hu_x, diff_x;

	assign dx = eff_dim(cfg.dim_x);
	assign dy = eff_dim(cfg.dim_y);
	assign dz = eff_dim(cfg.dim_z);
	assign coronal  = (cfg.orientation == csw_pkg::ORIENT_CORONAL);
	assign sagittal = (cfg.orientation == csw_pkg::ORIENT_SAGITTAL);
	assign axial    = !coronal && !sagittal;

	always_comb begin
		w     = sagittal ? dy : dx;
		h     = axial ? dy : dz;
		bstep = axial ? plane_q : (coronal ? PW'(dx) : PW'(1));
		rstep = axial ? PW'(dx) : plane_q;
		cstep = sagittal ? PW'(dx) : PW'(1);
		y2d   = axial ? DW'(row_q) : (h - DW'(1) - DW'(row_q));
	end

	assign col_nx  = (DW+1)'(col_q) + (DW+1)'(1);
	assign row_nx  = (DW+1)'(row_q) + (DW+1)'(1);
	assign row_end = (col_nx >= (DW+1)'(w));
	assign last    = row_end && (row_nx >= (DW+1)'(h));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (!row_end) begin
				col_q <= CW'(col_nx);
			end else begin
				col_q <= '0;
				row_q <= last ? '0 : CW'(row_nx);
			end
		end
	end

	// derived from configuration and registered; updates even while the chain is stalled
	always_ff @(posedge clk) begin
		plane_q <= PW'(dx) * PW'(dy);
		lo_q    <= $signed({cfg.window_level[csw_pkg::HuW-1], cfg.window_level})
			- $signed({2'b00, cfg.window_width[csw_pkg::WinW-1:1]});
		hi_q    <= $signed({cfg.window_level[csw_pkg::HuW-1], cfg.window_level})
			+ $signed({2'b00, cfg.window_width[csw_pkg::WinW-1:1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_acc;
			v_s2  <= v_s1;
			v_out <= v_s2;
		end
	end

	assign hu_x   = $signed({hu_s1[csw_pkg::HuW-1], hu_s1});
	assign diff_x = hu_x - lo_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1     <= col_q;
			r_s1     <= row_q;
			y2d_s1   <= y2d;
			hu_s1    <= hu;
			last_s1  <= last;

			base_s2  <= AW'(cfg.slice_index) * AW'(bstep);
			rowp_s2  <= AW'(r_s1) * AW'(rstep);
			colp_s2  <= AW'(c_s1) * AW'(cstep);
			dmul_s2  <= EW'(y2d_s1) * EW'(w);
			c_s2     <= c_s1;
			last_s2  <= last_s1;
			below_s2 <= (hu_x <= lo_q);
			above_s2 <= (hu_x >= hi_q);
			diff_s2  <= diff_x[csw_pkg::WinW-1:0];

			cell_out.addr  <= base_s2 + rowp_s2 + colp_s2;
			cell_out.dest  <= dmul_s2 + EW'(c_s2);
			cell_out.last  <= last_s2;
			cell_out.below <= below_s2;
			cell_out.above <= above_s2;
			cell_out.rem   <= {diff_s2, 8'd0} - {8'd0, diff_s2};
			cell_out.quo   <= '0;
		end
	end

endmodule

>>> src/csw_checker.sv
// Port-level checks for the CT slice window/level block, bound to its top.
// Depends on csw_pkg and ct_slice_window_level.
module csw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [csw_pkg::TdataW-1:0] m_tdata,
	input logic                       m_tlast,
	input logic                       pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while held");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output held");

	a_empty_takes_in: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused with output empty");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind ct_slice_window_level csw_checker u_csw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.pready   (pready)
);
